@@ rtl/core/bmiw_pkg.sv @@
// ----------------------------------------------------------------------------
// bmiw_pkg
// Shared types, constants and helpers of the block map indirect walker.
// ----------------------------------------------------------------------------
`default_nettype none

package bmiw_pkg;

    localparam int DIRECT_POINTERS = 12;
    localparam int TABLE_SLOTS     = DIRECT_POINTERS + 3;
    localparam int SLOT_W          = 4;
    localparam int LBN_W           = 48;
    localparam int WORD_W          = 32;
    localparam int WIDX_W          = 14;
    localparam int REM_W           = 43;
    localparam int LOG_W           = 3;
    localparam int SHIFT_W         = 4;
    localparam int SHIFT2_W        = SHIFT_W + 1;
    localparam int SHIFT3_W        = SHIFT_W + 2;
    localparam int MAX_LOG_BLOCK   = 6;
    localparam int BASE_SHIFT      = 8;

    localparam logic [SLOT_W-1:0] SLOT_SINGLE = SLOT_W'(DIRECT_POINTERS);
    localparam logic [SLOT_W-1:0] SLOT_DOUBLE = SLOT_W'(DIRECT_POINTERS + 1);
    localparam logic [SLOT_W-1:0] SLOT_TRIPLE = SLOT_W'(DIRECT_POINTERS + 2);

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_FINAL = 1'b1;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_XLATE = 2'd1,
        FUNC_RESP  = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_RDERR = 2'd2,
        ST_BUSY  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CLS_DIRECT,
        CLS_SINGLE,
        CLS_DOUBLE,
        CLS_TRIPLE,
        CLS_RANGE
    } cls_t;

    typedef struct packed {
        func_t              func;
        cls_t               cls;
        logic [LBN_W-1:0]   lbn;
        logic [WORD_W-1:0]  data_word;
        logic               read_failed;
    } item_t;

    typedef struct packed {
        logic               valid;
        logic               kind;
        logic [WORD_W-1:0]  read_block;
        logic [WIDX_W-1:0]  word_index;
        logic [WORD_W-1:0]  disk_block;
        status_t            status;
    } result_t;

    // Pointer-per-block shift: 8 plus the clamped log block size.
    function automatic logic [SHIFT_W-1:0] shift_of(input logic [LOG_W-1:0] lbs);
        logic [LOG_W-1:0] l;
        l = (lbs > LOG_W'(MAX_LOG_BLOCK)) ? LOG_W'(MAX_LOG_BLOCK) : lbs;
        return SHIFT_W'(BASE_SHIFT) + SHIFT_W'(l);
    endfunction

    // Upper bound of a level (0 direct .. 3 triple). The power-of-two terms
    // sit on distinct bits above the direct count, so OR equals the sum.
    function automatic logic [LBN_W-1:0] level_bound(input logic [SHIFT_W-1:0] s,
                                                     input logic [1:0] level);
        logic [LBN_W-1:0]    b;
        logic [SHIFT2_W-1:0] s2;
        logic [SHIFT3_W-1:0] s3;
        s2 = {s, 1'b0};
        s3 = SHIFT3_W'(s2) + SHIFT3_W'(s);
        b  = LBN_W'(DIRECT_POINTERS);
        if (level >= 2'd1) begin
            b = b | (LBN_W'(1) << s);
        end
        if (level >= 2'd2) begin
            b = b | (LBN_W'(1) << s2);
        end
        if (level == 2'd3) begin
            b = b | (LBN_W'(1) << s3);
        end
        return b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/bmiw_table_ram.sv @@
// ----------------------------------------------------------------------------
// bmiw_table_ram
// Pointer table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bmiw_table_ram (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [bmiw_pkg::SLOT_W-1:0] wr_addr,
    input  wire logic [bmiw_pkg::WORD_W-1:0] wr_data,
    input  wire logic                        rd_en,
    input  wire logic [bmiw_pkg::SLOT_W-1:0] rd_addr,
    output logic      [bmiw_pkg::WORD_W-1:0] rd_data
);

    logic [bmiw_pkg::WORD_W-1:0] mem [bmiw_pkg::TABLE_SLOTS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/bmiw_walk.sv @@
// ----------------------------------------------------------------------------
// bmiw_walk
// Walk state and result logic: answers translates, issues pointer reads and
// continues the walk on each read response.
// ----------------------------------------------------------------------------
`default_nettype none

module bmiw_walk (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         item_valid,
    input  wire bmiw_pkg::item_t              item,
    input  wire logic [bmiw_pkg::WORD_W-1:0]  table_word,
    input  wire logic [bmiw_pkg::SHIFT_W-1:0] shift,
    input  wire logic                         commit,
    output bmiw_pkg::result_t                 res
);

    logic                       pending_reg, pending_next;
    logic [1:0]                 levels_reg, levels_next;
    logic [bmiw_pkg::REM_W-1:0] rem_reg, rem_next;

    always_comb begin
        logic [bmiw_pkg::SHIFT2_W-1:0] s2;
        logic [bmiw_pkg::LBN_W-1:0]    idx;
        logic [bmiw_pkg::WIDX_W-1:0]   ppb_mask;
        logic [1:0]                    nxt;
        logic [bmiw_pkg::SHIFT2_W-1:0] sh;

        s2       = {shift, 1'b0};
        ppb_mask = bmiw_pkg::WIDX_W'(((bmiw_pkg::WIDX_W + 1)'(1) << shift)
                                     - (bmiw_pkg::WIDX_W + 1)'(1));
        idx      = '0;
        nxt      = levels_reg - 2'd1;
        sh       = '0;

        res            = '0;
        res.status     = bmiw_pkg::ST_OK;
        pending_next   = pending_reg;
        levels_next    = levels_reg;
        rem_next       = rem_reg;

        if (item_valid && item.func == bmiw_pkg::FUNC_XLATE) begin
            res.valid = 1'b1;
            res.kind  = bmiw_pkg::KIND_FINAL;
            if (pending_reg) begin
                res.status = bmiw_pkg::ST_BUSY;
            end else begin
                case (item.cls)
                    bmiw_pkg::CLS_DIRECT: begin
                        res.disk_block = table_word;
                    end
                    bmiw_pkg::CLS_SINGLE: begin
                        idx            = item.lbn - bmiw_pkg::level_bound(shift, 2'd0);
                        res.kind       = bmiw_pkg::KIND_READ;
                        res.read_block = table_word;
                        res.word_index = bmiw_pkg::WIDX_W'(idx);
                        pending_next   = 1'b1;
                        levels_next    = 2'd0;
                        rem_next       = '0;
                    end
                    bmiw_pkg::CLS_DOUBLE: begin
                        idx            = item.lbn - bmiw_pkg::level_bound(shift, 2'd1);
                        res.kind       = bmiw_pkg::KIND_READ;
                        res.read_block = table_word;
                        res.word_index = bmiw_pkg::WIDX_W'(idx >> shift);
                        pending_next   = 1'b1;
                        levels_next    = 2'd1;
                        rem_next       = bmiw_pkg::REM_W'(idx)
                                       & ((bmiw_pkg::REM_W'(1) << shift)
                                          - bmiw_pkg::REM_W'(1));
                    end
                    bmiw_pkg::CLS_TRIPLE: begin
                        idx            = item.lbn - bmiw_pkg::level_bound(shift, 2'd2);
                        res.kind       = bmiw_pkg::KIND_READ;
                        res.read_block = table_word;
                        res.word_index = bmiw_pkg::WIDX_W'(idx >> s2);
                        pending_next   = 1'b1;
                        levels_next    = 2'd2;
                        rem_next       = bmiw_pkg::REM_W'(idx)
                                       & ((bmiw_pkg::REM_W'(1) << s2)
                                          - bmiw_pkg::REM_W'(1));
                    end
                    default: begin
                        res.status = bmiw_pkg::ST_RANGE;
                    end
                endcase
            end
        end else if (item_valid && item.func == bmiw_pkg::FUNC_RESP && pending_reg) begin
            res.valid = 1'b1;
            if (item.read_failed) begin
                res.kind     = bmiw_pkg::KIND_FINAL;
                res.status   = bmiw_pkg::ST_RDERR;
                pending_next = 1'b0;
                levels_next  = 2'd0;
                rem_next     = '0;
            end else if (levels_reg == 2'd0) begin
                res.kind       = bmiw_pkg::KIND_FINAL;
                res.disk_block = item.data_word;
                pending_next   = 1'b0;
                rem_next       = '0;
            end else begin
                case (nxt)
                    2'd0:    sh = '0;
                    2'd1:    sh = bmiw_pkg::SHIFT2_W'(shift);
                    default: sh = s2;
                endcase
                res.kind       = bmiw_pkg::KIND_READ;
                res.read_block = item.data_word;
                res.word_index = bmiw_pkg::WIDX_W'(rem_reg >> sh) & ppb_mask;
                levels_next    = nxt;
                rem_next       = rem_reg & ((bmiw_pkg::REM_W'(1) << sh)
                                            - bmiw_pkg::REM_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 1'b0;
            levels_reg  <= 2'd0;
            rem_reg     <= '0;
        end else if (commit) begin
            pending_reg <= pending_next;
            levels_reg  <= levels_next;
            rem_reg     <= rem_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/block_map_indirect_walker.sv @@
// ----------------------------------------------------------------------------
// block_map_indirect_walker
// Logical-to-disk block translation through direct and indirect pointers.
// ----------------------------------------------------------------------------
// The block takes one request per clock while the result channel does not
// stall, for any mix of loads, translates and read responses. A request is
// classified in stage 0 (direct, single, double, triple, out of range) as the
// pointer table memory is read or written; in stage 1 the registered memory
// data is used to form the answer, which lands in the output register. The
// registered read of the pointer table RAM sets this pipeline depth. A direct
// translate answers with the final disk block; an indirect one answers with a
// read request (kind 0) for one pointer word, and each read response given
// back on the input continues the walk until the final answer (kind 1).
// While a walk is outstanding, further translates answer busy. The pointer
// table has no reset contents: load every slot before translating through it.
// No clearing pass after reset. Write log_block_size only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module block_map_indirect_walker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // configuration: log_block_size
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_wdata,
    // request channel
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // [3:0] slot, [51:4] logical_block, [83:52] data_word, [84] read_failed,
    // [87:85] zero
    input  wire logic [87:0]  s_tdata,
    // [1:0] func
    input  wire logic [1:0]   s_tuser,
    // result channel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] read_block, [45:32] word_index, [77:46] disk_block, [79:78] status
    output logic [79:0]       m_tdata,
    // [0] kind
    output logic [0:0]        m_tuser
);

    // Configuration register.
    logic [bmiw_pkg::LOG_W-1:0]   lbs_reg;
    logic [bmiw_pkg::SHIFT_W-1:0] shift;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lbs_reg <= '0;
        end else if (cfg_we) begin
            lbs_reg <= cfg_wdata;
        end
    end

    assign shift = bmiw_pkg::shift_of(lbs_reg);

    // Unpack the request.
    logic [bmiw_pkg::SLOT_W-1:0] in_slot;
    logic [bmiw_pkg::LBN_W-1:0]  in_lbn;
    logic [bmiw_pkg::WORD_W-1:0] in_word;
    logic                        in_failed;
    bmiw_pkg::func_t             in_func;

    assign in_slot   = s_tdata[3:0];
    assign in_lbn    = s_tdata[51:4];
    assign in_word   = s_tdata[83:52];
    assign in_failed = s_tdata[84];
    assign in_func   = bmiw_pkg::func_t'(s_tuser);

    // Pipeline control: stage 1 drains into the output register whenever
    // that register is empty or being taken this cycle.
    logic              st1_valid_reg;
    bmiw_pkg::item_t   st1_item_reg;
    logic              m_valid_reg;
    logic              out_free;
    logic              st1_adv;
    logic              s_accept;

    assign out_free = !m_valid_reg || m_tready;
    assign st1_adv  = st1_valid_reg && out_free;
    assign s_tready = !st1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    // Stage 0: classify the logical block against the level bounds.
    bmiw_pkg::cls_t              cls;
    logic [bmiw_pkg::SLOT_W-1:0] rd_addr;

    always_comb begin
        if (in_lbn < bmiw_pkg::level_bound(shift, 2'd0)) begin
            cls     = bmiw_pkg::CLS_DIRECT;
            rd_addr = in_lbn[bmiw_pkg::SLOT_W-1:0];
        end else if (in_lbn < bmiw_pkg::level_bound(shift, 2'd1)) begin
            cls     = bmiw_pkg::CLS_SINGLE;
            rd_addr = bmiw_pkg::SLOT_SINGLE;
        end else if (in_lbn < bmiw_pkg::level_bound(shift, 2'd2)) begin
            cls     = bmiw_pkg::CLS_DOUBLE;
            rd_addr = bmiw_pkg::SLOT_DOUBLE;
        end else if (in_lbn < bmiw_pkg::level_bound(shift, 2'd3)) begin
            cls     = bmiw_pkg::CLS_TRIPLE;
            rd_addr = bmiw_pkg::SLOT_TRIPLE;
        end else begin
            cls     = bmiw_pkg::CLS_RANGE;
            rd_addr = '0;
        end
    end

    // Loads write the table at once; a translate in the next cycle reads
    // the new value, so no forwarding is needed. Read data holds while
    // stage 1 is stalled, since the read only fires on accept.
    logic                        tbl_we;
    logic [bmiw_pkg::WORD_W-1:0] tbl_rdata;

    assign tbl_we = s_accept && in_func == bmiw_pkg::FUNC_LOAD
                 && in_slot < bmiw_pkg::SLOT_W'(bmiw_pkg::TABLE_SLOTS);

    bmiw_table_ram u_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (in_slot),
        .wr_data (in_word),
        .rd_en   (s_accept),
        .rd_addr (rd_addr),
        .rd_data (tbl_rdata)
    );

    // Stage 1 registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            st1_valid_reg <= 1'b1;
        end else if (st1_adv) begin
            st1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_item_reg.func        <= in_func;
            st1_item_reg.cls         <= cls;
            st1_item_reg.lbn         <= in_lbn;
            st1_item_reg.data_word   <= in_word;
            st1_item_reg.read_failed <= in_failed;
        end
    end

    // Stage 1: walk state and answer; state commits as the item leaves.
    bmiw_pkg::result_t res;

    bmiw_walk u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (st1_valid_reg),
        .item       (st1_item_reg),
        .table_word (tbl_rdata),
        .shift      (shift),
        .commit     (st1_adv),
        .res        (res)
    );

    // Output register.
    logic [79:0] m_data_reg;
    logic        m_kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st1_adv) begin
            m_valid_reg <= res.valid;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_adv && res.valid) begin
            m_data_reg <= {res.status, res.disk_block, res.word_index, res.read_block};
            m_kind_reg <= res.kind;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_kind_reg;

endmodule

`default_nettype wire

@@ sim/block_map_indirect_walker_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_map_indirect_walker_test
// Self-checking bench for the logical-to-disk block walker. It drives load,
// translate and read-response requests, mirrors the walk in a local
// predictor, and checks every result field against the predicted answer
// under sender gaps, receiver stalls and several block sizes.
// ----------------------------------------------------------------------------

module block_map_indirect_walker_test;

    import bmiw_pkg::*;

    // One predicted result, in the field order of the result channel.
    typedef struct packed {
        logic               kind;
        logic [WORD_W-1:0]  read_block;
        logic [WIDX_W-1:0]  word_index;
        logic [WORD_W-1:0]  disk_block;
        status_t            status;
    } walk_answer_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_we    = 1'b0;
    logic [2:0]   cfg_wdata = 3'd0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [87:0]  s_tdata   = '0;
    logic [1:0]   s_tuser   = FUNC_NONE;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [79:0]  m_tdata;
    logic [0:0]   m_tuser;

    // Predictor state: pointer table copy, block size and the open walk.
    logic [WORD_W-1:0]  ptr_words [TABLE_SLOTS];
    logic [LOG_W-1:0]   blk_log     = '0;
    logic               chain_open  = 1'b0;
    logic [1:0]         hops_left   = '0;
    logic [REM_W-1:0]   index_below = '0;

    walk_answer_t       answers_due [$];
    int                 mismatch_count = 0;
    int                 send_gap_pct   = 0;
    int                 recv_stall_pct = 0;

    // Block sizes for the random phases, two per idling mode; 7 clamps to 6.
    logic [2:0]         size_plan [6] = '{3'd0, 3'd7, 3'd6, 3'd2, 3'd5, 3'd1};

    block_map_indirect_walker u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Pointers per block as a shift: 8 plus the clamped log block size.
    function automatic int ptr_shift();
        return BASE_SHIFT + ((blk_log > MAX_LOG_BLOCK) ? MAX_LOG_BLOCK : int'(blk_log));
    endfunction

    // First logical block past level lvl (0 direct, 1 single, 2 double, 3 triple).
    function automatic logic [63:0] span_end(input int lvl);
        logic [63:0] b;
        int          sh;
        sh = ptr_shift();
        b  = 64'(DIRECT_POINTERS);
        for (int i = 1; i <= lvl; i++) begin
            b = b + (64'd1 << (i * sh));
        end
        return b;
    endfunction

    // Advance the predicted walk by one accepted request; return 1 when the
    // request produces a result, which is placed in ans.
    function automatic bit predict_walk(input func_t fn, input logic [SLOT_W-1:0] slot,
                                        input logic [LBN_W-1:0] lbn,
                                        input logic [WORD_W-1:0] word,
                                        input logic failed, output walk_answer_t ans);
        int          sh;
        int          shn;
        logic [63:0] per_blk;
        logic [63:0] idx;
        logic [63:0] below;
        ans     = '0;
        sh      = ptr_shift();
        per_blk = 64'd1 << sh;
        case (fn)
            FUNC_LOAD: begin
                // Drop loads aimed past the table.
                if (slot < TABLE_SLOTS) begin
                    ptr_words[slot] = word;
                end
                return 1'b0;
            end
            FUNC_XLATE: begin
                ans.kind = KIND_FINAL;
                if (chain_open) begin
                    ans.status = ST_BUSY;
                    return 1'b1;
                end
                if (lbn < span_end(0)) begin
                    ans.disk_block = ptr_words[lbn[SLOT_W-1:0]];
                    return 1'b1;
                end
                for (int k = 1; k <= 3; k++) begin
                    if (lbn < span_end(k)) begin
                        idx            = 64'(lbn) - span_end(k - 1);
                        shn            = sh * (k - 1);
                        ans.kind       = KIND_READ;
                        ans.read_block = ptr_words[DIRECT_POINTERS + k - 1];
                        ans.word_index = WIDX_W'(idx >> shn);
                        chain_open     = 1'b1;
                        hops_left      = 2'(k - 1);
                        index_below    = REM_W'(idx & ((64'd1 << shn) - 64'd1));
                        return 1'b1;
                    end
                end
                ans.status = ST_RANGE;
                return 1'b1;
            end
            FUNC_RESP: begin
                if (!chain_open) begin
                    return 1'b0;
                end
                ans.kind = KIND_FINAL;
                if (failed) begin
                    chain_open  = 1'b0;
                    hops_left   = '0;
                    index_below = '0;
                    ans.status  = ST_RDERR;
                    return 1'b1;
                end
                if (hops_left == 2'd0) begin
                    chain_open     = 1'b0;
                    index_below    = '0;
                    ans.disk_block = word;
                    return 1'b1;
                end
                // Descend one level, with the current shift.
                hops_left      = hops_left - 2'd1;
                shn            = sh * int'(hops_left);
                below          = 64'(index_below);
                ans.kind       = KIND_READ;
                ans.read_block = word;
                ans.word_index = WIDX_W'((below >> shn) & (per_blk - 64'd1));
                index_below    = REM_W'(below & ((64'd1 << shn) - 64'd1));
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    // Pick a logical block in level lvl (4 means beyond the triple range),
    // leaning on the first and the last block of the level.
    function automatic logic [LBN_W-1:0] pick_lbn(input int lvl);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] off;
        lo = (lvl == 0) ? 64'd0 : span_end(lvl - 1);
        hi = (lvl == 4) ? 64'hFFFF_FFFF_FFFF : span_end(lvl) - 64'd1;
        case ($urandom_range(3))
            0:       off = 64'd0;
            1:       off = hi - lo;
            default: off = {$urandom, $urandom} % (hi - lo + 64'd1);
        endcase
        return LBN_W'(lo + off);
    endfunction

    // Send one request: idle at random, present it, hold until accepted,
    // then record the predicted result.
    task automatic send_request(input func_t fn, input logic [SLOT_W-1:0] slot,
                                input logic [LBN_W-1:0] lbn, input logic [WORD_W-1:0] word,
                                input logic failed);
        walk_answer_t ans;
        while ($urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {3'b000, failed, word, lbn, slot};
        do @(posedge aclk); while (!s_tready);
        if (predict_walk(fn, slot, lbn, word, failed, ans)) begin
            answers_due.push_back(ans);
        end
    endtask

    // Drop valid and wait for every predicted result, then let the pipeline
    // empty of requests that produce none.
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic set_block_shift(input logic [2:0] v);
        settle_block();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we  <= 1'b0;
        blk_log  = v;
    endtask

    // Fill every table slot, so no later walk reads an unwritten pointer, and
    // poke the requests the block must drop.
    task automatic test_table_loads();
        for (int i = 0; i < TABLE_SLOTS; i++) begin
            send_request(FUNC_LOAD, SLOT_W'(i), pick_lbn(4),
                         (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom, i[0]);
        end
        send_request(FUNC_LOAD, SLOT_W'(TABLE_SLOTS), '1, 32'hDEAD_BEEF, 1'b1);
        send_request(FUNC_NONE, '1, '1, '1, 1'b1);
    endtask

    // Hand-picked walks at the reset block size: direct edges, each indirect
    // depth, busy, stray response, failed read and both range edges.
    task automatic test_directed_walks();
        send_request(FUNC_XLATE, '0, 48'd0, '0, 1'b0);
        send_request(FUNC_XLATE, '0, 48'd11, '0, 1'b0);
        send_request(FUNC_XLATE, '0, 48'd12, '0, 1'b0);
        send_request(FUNC_XLATE, '0, 48'd0, '0, 1'b0);
        send_request(FUNC_RESP, '0, '0, 32'hFFFF_FFFF, 1'b0);
        send_request(FUNC_RESP, '0, '0, 32'h1234_5678, 1'b0);
        send_request(FUNC_XLATE, '0, LBN_W'(span_end(2) - 64'd1), '0, 1'b0);
        send_request(FUNC_RESP, '0, '0, 32'h8000_0001, 1'b0);
        send_request(FUNC_RESP, '0, '0, 32'h0000_0000, 1'b0);
        send_request(FUNC_XLATE, '0, LBN_W'(span_end(2)), '0, 1'b0);
        send_request(FUNC_RESP, '0, '0, $urandom, 1'b0);
        send_request(FUNC_RESP, '0, '0, $urandom, 1'b1);
        send_request(FUNC_XLATE, '0, LBN_W'(span_end(3)), '0, 1'b0);
        send_request(FUNC_XLATE, '0, 48'hFFFF_FFFF_FFFF, '0, 1'b0);
    endtask

    // Change the block size twice while a triple walk waits on its reads.
    task automatic test_resize_mid_walk();
        set_block_shift(3'd0);
        send_request(FUNC_XLATE, '0, LBN_W'(span_end(2) + 64'h12_3456), '0, 1'b0);
        set_block_shift(3'd7);
        send_request(FUNC_RESP, '0, '0, $urandom, 1'b0);
        set_block_shift(3'd3);
        send_request(FUNC_RESP, '0, '0, $urandom, 1'b0);
        send_request(FUNC_RESP, '0, '0, $urandom, 1'b0);
    endtask

    // Mostly complete walks with random content; busy translates, loads and
    // noise are mixed into the walks, and some requests stand alone.
    task automatic test_random_walks(input int count);
        int sent;
        int pick;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_request(FUNC_XLATE, SLOT_W'($urandom), pick_lbn($urandom_range(3)),
                             $urandom, 1'($urandom));
                sent++;
                while (chain_open) begin
                    pick = $urandom_range(99);
                    if (pick < 8) begin
                        send_request(FUNC_XLATE, SLOT_W'($urandom),
                                     pick_lbn($urandom_range(4)), $urandom, 1'($urandom));
                        sent++;
                    end else if (pick < 14) begin
                        send_request(FUNC_LOAD, SLOT_W'($urandom_range(TABLE_SLOTS - 1)),
                                     pick_lbn(4), $urandom, 1'($urandom));
                        sent++;
                    end else if (pick < 17) begin
                        send_request(FUNC_NONE, SLOT_W'($urandom), pick_lbn(4),
                                     $urandom, 1'($urandom));
                    end else begin
                        send_request(FUNC_RESP, SLOT_W'($urandom), pick_lbn(4), $urandom,
                                     ($urandom_range(19) == 0));
                        sent++;
                    end
                end
            end else if (pick < 80) begin
                send_request(FUNC_XLATE, SLOT_W'($urandom), pick_lbn(4), $urandom,
                             1'($urandom));
                sent++;
            end else if (pick < 88) begin
                send_request(FUNC_LOAD, SLOT_W'($urandom_range(TABLE_SLOTS - 1)),
                             pick_lbn(4), $urandom, 1'($urandom));
                sent++;
            end else if (pick < 94) begin
                // Response with no walk open: the block drops it.
                send_request(FUNC_RESP, SLOT_W'($urandom), pick_lbn(4), $urandom,
                             1'($urandom));
            end else if (pick < 97) begin
                send_request(FUNC_NONE, SLOT_W'($urandom), pick_lbn(4), $urandom,
                             1'($urandom));
            end else begin
                send_request(FUNC_LOAD, SLOT_W'(TABLE_SLOTS), pick_lbn(4), $urandom,
                             1'($urandom));
            end
        end
    endtask

    function automatic void check_field(input string what, input logic [WORD_W-1:0] want,
                                        input logic [WORD_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
            mismatch_count++;
        end
    endfunction

    // Stall the result channel at random.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each accepted result with the oldest predicted one.
    always @(posedge aclk) begin : check_results
        walk_answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (answers_due.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual kind %h data %h",
                         $time, m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                want = answers_due.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_tuser[0]));
                check_field("read_block", want.read_block, m_tdata[31:0]);
                check_field("word_index", 32'(want.word_index), 32'(m_tdata[45:32]));
                check_field("disk_block", want.disk_block, m_tdata[77:46]);
                check_field("status", 32'(want.status), 32'(m_tdata[79:78]));
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_gap_pct   = 15;
        recv_stall_pct = 71;
        test_table_loads();
        test_directed_walks();
        test_resize_mid_walk();

        // Swap the idling sides, then run with no idling at all.
        for (int mode = 0; mode < 3; mode++) begin
            send_gap_pct   = (mode == 0) ? 15 : (mode == 1) ? 71 : 0;
            recv_stall_pct = (mode == 0) ? 71 : (mode == 1) ? 15 : 0;
            for (int k = 0; k < 2; k++) begin
                set_block_shift(size_plan[2 * mode + k]);
                test_random_walks(100);
            end
        end

        settle_block();
        if (mismatch_count == 0 && answers_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hold a hard limit far above the slowest correct run.
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/bmiw_pkg.sv
rtl/core/bmiw_table_ram.sv
rtl/core/bmiw_walk.sv
rtl/core/block_map_indirect_walker.sv
sim/block_map_indirect_walker_test.sv
